// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; clock clk and active-low reset rst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/ubfr_pkg.sv
// Package for the boot frame receiver: types, constants and the CRC / frame check functions.
package ubfr_pkg;

  localparam int DEFAULT_BUFFER_BYTES = 1024;

  localparam logic [7:0]  START_BYTE  = 8'hF1;
  localparam logic [7:0]  END_BYTE    = 8'hF2;
  localparam logic [15:0] CRC_GENPOLY = 16'h1021;
  localparam logic [15:0] CRC_SEED    = 16'h0000;
  localparam logic [15:0] CRC_BYPASS  = 16'h55AA;
  localparam logic [15:0] FIXED_LEN   = 16'd14;

  localparam logic [7:0] CMD_0 = 8'h70;
  localparam logic [7:0] CMD_1 = 8'h71;
  localparam logic [7:0] CMD_2 = 8'h72;

  // Header layout: start, address, command, length high, length low.
  localparam int POS_START  = 0;
  localparam int POS_ADDR   = 1;
  localparam int POS_CMD    = 2;
  localparam int POS_LEN_HI = 3;
  localparam int POS_LEN_LO = 4;
  localparam int HDR_BYTES  = 5;
  localparam int CRC_BYTES  = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FRAME,
    S_HOLD
  } state_t;

  typedef enum logic [2:0] {
    FS_OK       = 3'd0,
    FS_BAD_ADDR = 3'd1,
    FS_BAD_CMD  = 3'd2,
    FS_BAD_LEN  = 3'd3,
    FS_BAD_CRC  = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_length;
  } out_item_t;

  // CRC16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_GENPOLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic frame_status_t frame_check(
    input logic [7:0]  addr,
    input logic [7:0]  own,
    input logic [7:0]  cmd,
    input logic [15:0] len,
    input logic [15:0] rx_crc,
    input logic [15:0] calc_crc
  );
    frame_status_t s;
    if (addr != own) begin
      s = FS_BAD_ADDR;
    end else if (cmd != CMD_0 && cmd != CMD_1 && cmd != CMD_2) begin
      s = FS_BAD_CMD;
    end else if ((cmd == CMD_0 || cmd == CMD_2) && len != FIXED_LEN) begin
      s = FS_BAD_LEN;
    end else if (rx_crc != CRC_BYPASS && rx_crc != calc_crc) begin
      s = FS_BAD_CRC;
    end else begin
      s = FS_OK;
    end
    return s;
  endfunction

endpackage

// File: rtl/core/ubfr_in_if.sv
// Input channel: received byte or release event, valid/ready handshake.
interface ubfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// File: rtl/core/ubfr_out_if.sv
// Result channel: payload byte and frame report, valid/ready handshake.
interface ubfr_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic [7:0]  frame_cmd;
  logic [15:0] frame_length;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_done, output frame_status, output frame_cmd, output frame_length,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_done, input frame_status, input frame_cmd, input frame_length,
    output ready
  );
endinterface

// File: rtl/core/ubfr_deframer.sv
// Frame parser: state machine, position counter, running CRC and per-transaction result.
`include "assert_macros.svh"

module ubfr_deframer #(
  parameter int BUFFER_BYTES = ubfr_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                op,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          own_address,
  output ubfr_pkg::out_item_t res
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam logic [PW-1:0] POS_LAST = PW'(BUFFER_BYTES - 1);

  ubfr_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      rcrc_r, rcrc_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       cmd_r, cmd_nxt;

  logic          start;
  logic          active;
  logic [PW-1:0] pos_base;
  logic          wrap;
  logic [PW-1:0] pos_eff;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] pos_idx;
  logic [15:0]   crc_base;
  logic [15:0]   len_base;
  logic [15:0]   crc_fed;
  logic [16:0]   pos_x;
  logic [16:0]   len_x;
  logic          in_hdr;
  logic          in_body;
  logic          in_data;
  logic          at_end;
  logic          drop;
  logic          end_ok;

  assign start    = (state_r == ubfr_pkg::S_IDLE) && (rx_byte == ubfr_pkg::START_BYTE);
  assign active   = !op && ((state_r == ubfr_pkg::S_FRAME) || start);
  assign pos_base = start ? '0 : pos_r;
  // Counter reaching buffer end restarts the frame at this byte.
  assign wrap     = (pos_base == POS_LAST);
  assign pos_eff  = wrap ? '0 : pos_base;
  assign pos_inc  = pos_eff + PW'(1);
  assign pos_idx  = pos_eff - PW'(ubfr_pkg::HDR_BYTES);
  assign crc_base = (start || wrap) ? ubfr_pkg::CRC_SEED : crc_r;
  assign len_base = start ? 16'h0000 : len_r;
  assign crc_fed  = ubfr_pkg::crc_feed(crc_base, rx_byte);

  assign pos_x   = 17'(pos_eff);
  assign len_x   = {1'b0, len_base};
  assign in_hdr  = (pos_x < 17'(ubfr_pkg::HDR_BYTES));
  assign in_body = !in_hdr && (pos_x < len_x + 17'(ubfr_pkg::HDR_BYTES + ubfr_pkg::CRC_BYTES));
  assign in_data = in_body && (pos_x < len_x + 17'(ubfr_pkg::HDR_BYTES));
  assign at_end  = !in_hdr && (pos_x == len_x + 17'(ubfr_pkg::HDR_BYTES + ubfr_pkg::CRC_BYTES));
  assign drop    = !in_hdr && !in_body && !at_end;
  assign end_ok  = at_end && (rx_byte == ubfr_pkg::END_BYTE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ubfr_pkg::S_IDLE: begin
        if (active) begin
          state_nxt = ubfr_pkg::S_FRAME;
        end
      end
      ubfr_pkg::S_FRAME: begin
        if (active && drop) begin
          state_nxt = ubfr_pkg::S_IDLE;
        end else if (active && end_ok) begin
          state_nxt = ubfr_pkg::S_HOLD;
        end
      end
      ubfr_pkg::S_HOLD: begin
        if (op) begin
          state_nxt = ubfr_pkg::S_IDLE;
        end
      end
      default: state_nxt = ubfr_pkg::S_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    crc_nxt  = crc_r;
    rcrc_nxt = rcrc_r;
    addr_nxt = addr_r;
    cmd_nxt  = cmd_r;
    res      = '0;

    if (op && state_r == ubfr_pkg::S_HOLD) begin
      pos_nxt = '0;
    end else if (active) begin
      len_nxt = len_base;
      crc_nxt = crc_base;
      if (in_hdr) begin
        case (pos_eff)
          PW'(ubfr_pkg::POS_ADDR):   addr_nxt = rx_byte;
          PW'(ubfr_pkg::POS_CMD):    cmd_nxt  = rx_byte;
          PW'(ubfr_pkg::POS_LEN_HI): len_nxt  = {rx_byte, 8'h00};
          PW'(ubfr_pkg::POS_LEN_LO): len_nxt  = {len_base[15:8], rx_byte};
          default: ;
        endcase
        crc_nxt = (pos_eff == PW'(ubfr_pkg::POS_START)) ? ubfr_pkg::CRC_SEED : crc_fed;
        pos_nxt = pos_inc;
      end else if (in_body) begin
        if (in_data) begin
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = 16'(pos_idx);
          crc_nxt           = crc_fed;
        end else begin
          rcrc_nxt = {rcrc_r[7:0], rx_byte};
        end
        pos_nxt = pos_inc;
      end else if (at_end) begin
        if (end_ok) begin
          res.frame_done   = 1'b1;
          res.frame_status = ubfr_pkg::frame_check(addr_r, own_address, cmd_r, len_base,
                                                   rcrc_r, crc_base);
          res.frame_cmd    = cmd_r;
          res.frame_length = len_base;
        end
        pos_nxt = pos_inc;
      end else begin
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ubfr_pkg::S_IDLE;
      pos_r   <= '0;
      len_r   <= '0;
      crc_r   <= ubfr_pkg::CRC_SEED;
      rcrc_r  <= '0;
      addr_r  <= '0;
      cmd_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  `ASSERT_NEXT(a_done_holds, step && res.frame_done, state_r == ubfr_pkg::S_HOLD)
  `ASSERT_NEXT(a_hold_ignores_bytes, step && !op && state_r == ubfr_pkg::S_HOLD,
               state_r == ubfr_pkg::S_HOLD)

endmodule

// File: rtl/core/uart_boot_frame_receiver.sv
// Boot frame receiver top level. Takes one UART byte or release event per transaction and
// returns exactly one result per transaction: a data byte with its index, a frame report on
// a correct end byte (0xF2), or an all-zero result. Frames are start 0xF1, address, command,
// 16-bit length, data, 16-bit CRC16-CCITT (init 0) and end byte; after a report the block
// ignores bytes until a release event. The parser and CRC byte update sit between the input
// handshake and a single result register, and a new transaction is accepted every cycle
// while that register is empty or being drained.
// cfg_wdata loads the own address when cfg_we is high; write it only while idle.
`include "assert_macros.svh"

module uart_boot_frame_receiver #(
  parameter int BUFFER_BYTES = ubfr_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  ubfr_in_if.sink    in_ch,
  ubfr_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]          own_addr_r;
  logic                out_valid_r, out_valid_nxt;
  ubfr_pkg::out_item_t out_item_r;
  ubfr_pkg::out_item_t res;
  logic                in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
    end else if (cfg_we) begin
      own_addr_r <= cfg_wdata;
    end
  end

  ubfr_deframer #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_deframer (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .op          (in_ch.op),
    .rx_byte     (in_ch.rx_byte),
    .own_address (own_addr_r),
    .res         (res)
  );

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_valid = out_item_r.payload_valid;
  assign out_ch.payload_byte  = out_item_r.payload_byte;
  assign out_ch.payload_index = out_item_r.payload_index;
  assign out_ch.frame_done    = out_item_r.frame_done;
  assign out_ch.frame_status  = out_item_r.frame_status;
  assign out_ch.frame_cmd     = out_item_r.frame_cmd;
  assign out_ch.frame_length  = out_item_r.frame_length;

  `ASSERT_NEXT(a_result_follows, in_fire, out_valid_r)
  `ASSERT_IMPLIES(a_result_kind, out_valid_r,
                  !(out_item_r.payload_valid && out_item_r.frame_done))
  `ASSERT_NEXT(a_cfg_seen, cfg_we, own_addr_r == $past(cfg_wdata))

endmodule

// File: tb/uart_boot_frame_receiver_tb.sv
// Self-checking testbench for uart_boot_frame_receiver: directed frames, then random frames.
`timescale 1ns / 100ps

module uart_boot_frame_receiver_tb;

  localparam int BUF_BYTES  = ubfr_pkg::DEFAULT_BUFFER_BYTES;
  localparam int LONG_STALL = 400;

  typedef struct {
    logic                op;
    logic [7:0]          rx_byte;
    bit                  pinned;
    ubfr_pkg::out_item_t result;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  ubfr_in_if  in_if ();
  ubfr_out_if out_if ();

  uart_boot_frame_receiver #(.BUFFER_BYTES(BUF_BYTES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Watchdog
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Deframer state as seen by the checker
  logic [7:0]  own_addr_model = 8'h00;
  logic        in_frame_q     = 1'b0;
  logic        hold_q         = 1'b0;
  logic [9:0]  pos_q          = '0;
  logic [15:0] len_q          = '0;
  logic [15:0] crc_q          = ubfr_pkg::CRC_SEED;
  logic [15:0] rx_crc_q       = '0;
  logic [7:0]  addr_q         = '0;
  logic [7:0]  cmd_q          = '0;

  stim_row_t           byte_feed[$];
  ubfr_pkg::out_item_t pending_results[$];
  stim_row_t           on_bus;
  stim_row_t           directed_rows [24];

  bit quiet         = 1'b0;
  bit stall_request = 1'b0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int stall_left    = 0;
  int fed_items     = 0;
  int failures      = 0;
  int transactions  = 0;
  int payload_bytes = 0;
  int frame_reports [8];

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ ubfr_pkg::CRC_GENPOLY) : {c[14:0], 1'b0};
    return c;
  endfunction

  // Advance the deframer by one transaction and return the result it should produce.
  function automatic ubfr_pkg::out_item_t deframe_step(input logic op, input logic [7:0] b);
    ubfr_pkg::out_item_t r;
    int                  pos;
    int                  len;
    r = '0;
    if (op) begin
      if (hold_q) begin
        hold_q     = 1'b0;
        in_frame_q = 1'b0;
        pos_q      = '0;
      end
      return r;
    end
    if (hold_q) return r;
    if (!in_frame_q && b == ubfr_pkg::START_BYTE) begin
      in_frame_q = 1'b1;
      pos_q      = '0;
      len_q      = '0;
      crc_q      = ubfr_pkg::CRC_SEED;
    end
    if (!in_frame_q) return r;
    // buffer wrap: byte is taken as a fresh start byte
    if (pos_q == 10'(BUF_BYTES - 1)) begin
      pos_q = '0;
      crc_q = ubfr_pkg::CRC_SEED;
    end
    pos = pos_q;
    len = len_q;
    if (pos < ubfr_pkg::HDR_BYTES) begin
      case (pos)
        ubfr_pkg::POS_ADDR:   addr_q = b;
        ubfr_pkg::POS_CMD:    cmd_q = b;
        ubfr_pkg::POS_LEN_HI: len_q = {b, 8'h00};
        ubfr_pkg::POS_LEN_LO: len_q[7:0] = b;
        default:              crc_q = ubfr_pkg::CRC_SEED;
      endcase
      if (pos != ubfr_pkg::POS_START) crc_q = crc16_byte(crc_q, b);
      pos_q = pos_q + 10'd1;
    end else if (pos < ubfr_pkg::HDR_BYTES + ubfr_pkg::CRC_BYTES + len) begin
      if (pos < ubfr_pkg::HDR_BYTES + len) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = 16'(pos - ubfr_pkg::HDR_BYTES);
        crc_q = crc16_byte(crc_q, b);
      end else begin
        rx_crc_q = {rx_crc_q[7:0], b};
      end
      pos_q = pos_q + 10'd1;
    end else if (pos == ubfr_pkg::HDR_BYTES + ubfr_pkg::CRC_BYTES + len) begin
      if (b == ubfr_pkg::END_BYTE) begin
        hold_q       = 1'b1;
        r.frame_done = 1'b1;
        r.frame_cmd  = cmd_q;
        r.frame_length = len_q;
        if (addr_q != own_addr_model)
          r.frame_status = ubfr_pkg::FS_BAD_ADDR;
        else if (cmd_q != ubfr_pkg::CMD_0 && cmd_q != ubfr_pkg::CMD_1 &&
                 cmd_q != ubfr_pkg::CMD_2)
          r.frame_status = ubfr_pkg::FS_BAD_CMD;
        else if ((cmd_q == ubfr_pkg::CMD_0 || cmd_q == ubfr_pkg::CMD_2) &&
                 len_q != ubfr_pkg::FIXED_LEN)
          r.frame_status = ubfr_pkg::FS_BAD_LEN;
        else if (rx_crc_q != ubfr_pkg::CRC_BYPASS && rx_crc_q != crc_q)
          r.frame_status = ubfr_pkg::FS_BAD_CRC;
        else
          r.frame_status = ubfr_pkg::FS_OK;
      end
      pos_q = pos_q + 10'd1;
    end else begin
      // byte after a wrong end byte is dropped
      in_frame_q = 1'b0;
      pos_q      = '0;
    end
    return r;
  endfunction

  function automatic stim_row_t row(input logic op, input logic [7:0] b,
                                    input ubfr_pkg::out_item_t r);
    stim_row_t s;
    s.op      = op;
    s.rx_byte = b;
    s.pinned  = 1'b1;
    s.result  = r;
    return s;
  endfunction

  task automatic feed(input logic op, input logic [7:0] b, input bit counts);
    stim_row_t s;
    s.op      = op;
    s.rx_byte = b;
    s.pinned  = 1'b0;
    s.result  = '0;
    byte_feed.push_back(s);
    if (counts) fed_items++;
  endtask

  // One frame with random content. long_data runs the data field up to the buffer wrap;
  // at_wrap means the lead byte lands on the wrap and need not be a start byte.
  task automatic queue_frame(input bit long_data, input bit at_wrap);
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  d;
    logic [15:0] len;
    logic [15:0] crc;
    int          n_data;
    int          pick;
    feed(1'b0, at_wrap ? 8'($urandom_range(0, 255)) : ubfr_pkg::START_BYTE, 1'b1);
    addr = ($urandom_range(0, 9) < 7) ? own_addr_model : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0, 1:    cmd = ubfr_pkg::CMD_0;
      2, 3:    cmd = ubfr_pkg::CMD_1;
      4, 5:    cmd = ubfr_pkg::CMD_2;
      default: cmd = 8'($urandom_range(0, 255));
    endcase
    if (long_data)
      len = 16'($urandom_range(1100, 65535));
    else if ((cmd == ubfr_pkg::CMD_0 || cmd == ubfr_pkg::CMD_2) && $urandom_range(0, 4) != 0)
      len = ubfr_pkg::FIXED_LEN;
    else
      len = 16'($urandom_range(0, 20));
    feed(1'b0, addr, 1'b1);
    feed(1'b0, cmd, 1'b1);
    feed(1'b0, len[15:8], 1'b1);
    feed(1'b0, len[7:0], 1'b1);
    crc = crc16_byte(crc16_byte(crc16_byte(crc16_byte(ubfr_pkg::CRC_SEED, addr), cmd),
                                len[15:8]), len[7:0]);
    n_data = long_data ? BUF_BYTES - 1 - ubfr_pkg::HDR_BYTES : int'(len);
    for (int i = 0; i < n_data; i++) begin
      d   = 8'($urandom_range(0, 255));
      crc = crc16_byte(crc, d);
      feed(1'b0, d, 1'b1);
    end
    if (long_data) return;
    pick = $urandom_range(0, 9);
    if (pick >= 8)
      crc = 16'($urandom);
    else if (pick >= 6)
      crc = ubfr_pkg::CRC_BYPASS;
    feed(1'b0, crc[15:8], 1'b1);
    feed(1'b0, crc[7:0], 1'b1);
    if ($urandom_range(0, 9) != 0) begin
      feed(1'b0, ubfr_pkg::END_BYTE, 1'b1);
      repeat ($urandom_range(0, 2)) feed(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      feed(1'b1, 8'($urandom_range(0, 255)), 1'b1);
    end else begin
      d = 8'($urandom_range(0, 255));
      if (d == ubfr_pkg::END_BYTE) d = 8'h00;
      feed(1'b0, d, 1'b1);
      feed(1'b0, ($urandom_range(0, 2) == 0) ? ubfr_pkg::START_BYTE :
                 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic run_frames(input int n_items);
    int         start;
    logic [7:0] b;
    start = fed_items;
    while (fed_items - start < n_items) begin
      // idle-line noise: stray releases and non-start bytes
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1)) begin
            feed(1'b1, b, 1'b0);
          end else begin
            if (b == ubfr_pkg::START_BYTE) b = ~b;
            feed(1'b0, b, 1'b0);
          end
        end
      end
      queue_frame(1'b0, 1'b0);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_feed.size() != 0 || in_if.valid || pending_results.size() != 0);
  endtask

  task automatic load_own_address(input logic [7:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    own_addr_model = value;
    @(negedge clk);
  endtask

  task automatic note_failure(input string what, input ubfr_pkg::out_item_t want,
                              input ubfr_pkg::out_item_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t %s: expected pv=%0d byte=%h idx=%0d done=%0d st=%0d cmd=%h len=%0d",
               $time, what, want.payload_valid, want.payload_byte, want.payload_index,
               want.frame_done, want.frame_status, want.frame_cmd, want.frame_length);
      $display("    actual   pv=%0d byte=%h idx=%0d done=%0d st=%0d cmd=%h len=%0d",
               got.payload_valid, got.payload_byte, got.payload_index,
               got.frame_done, got.frame_status, got.frame_cmd, got.frame_length);
    end
  endtask

  // Byte source
  always @(posedge clk) begin : sender
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(1, 8) - 1;
        in_if.valid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
        on_bus         <= byte_feed[0];
        in_if.op       <= byte_feed[0].op;
        in_if.rx_byte  <= byte_feed[0].rx_byte;
        in_if.valid    <= 1'b1;
        void'(byte_feed.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink, with random back-pressure and one long hold-off on request
  always @(posedge clk) begin : receiver
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (stall_request) begin
      stall_request = 1'b0;
      stall_left    = LONG_STALL - 1;
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 8) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Predict on every accepted input transaction, check every accepted result
  always @(posedge clk) begin : monitor
    ubfr_pkg::out_item_t want;
    ubfr_pkg::out_item_t got;
    if (rst_n && in_if.valid && in_if.ready) begin
      want = deframe_step(in_if.op, in_if.rx_byte);
      if (on_bus.pinned) want = on_bus.result;
      pending_results.push_back(want);
      transactions++;
      if (want.payload_valid) payload_bytes++;
      if (want.frame_done) frame_reports[want.frame_status]++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.payload_valid, out_if.payload_byte, out_if.payload_index,
             out_if.frame_done, out_if.frame_status, out_if.frame_cmd, out_if.frame_length};
      if (pending_results.size() == 0) begin
        note_failure("result with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte ||
            got.payload_index !== want.payload_index || got.frame_done !== want.frame_done ||
            got.frame_status !== want.frame_status || got.frame_cmd !== want.frame_cmd ||
            got.frame_length !== want.frame_length)
          note_failure("result mismatch", want, got);
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.op      = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    rst_n         = 1'b0;
    on_bus        = row(1'b0, 8'h00, '0);

    // own address is 0 out of reset
    directed_rows = '{
      row(1'b1, 8'hFF, '0),              // release while idle
      row(1'b0, 8'h00, '0),
      row(1'b0, ubfr_pkg::END_BYTE, '0),
      row(1'b0, ubfr_pkg::START_BYTE, '0),
      row(1'b0, 8'h00, '0),
      row(1'b0, ubfr_pkg::CMD_1, '0),
      row(1'b0, 8'h00, '0),
      row(1'b0, 8'h02, '0),
      row(1'b0, ubfr_pkg::START_BYTE, '{payload_valid: 1'b1,
                                        payload_byte: ubfr_pkg::START_BYTE, default: '0}),
      row(1'b0, 8'hFF, '{payload_valid: 1'b1, payload_byte: 8'hFF, payload_index: 16'd1,
                         default: '0}),
      row(1'b0, ubfr_pkg::CRC_BYPASS[15:8], '0),
      row(1'b0, ubfr_pkg::CRC_BYPASS[7:0], '0),
      row(1'b0, 8'h00, '0),              // wrong end byte drops the frame
      row(1'b0, ubfr_pkg::START_BYTE, '0),   // swallowed
      row(1'b0, ubfr_pkg::START_BYTE, '0),
      row(1'b0, 8'hFF, '0),
      row(1'b0, 8'h00, '0),
      row(1'b0, 8'h00, '0),
      row(1'b0, 8'h00, '0),
      row(1'b0, 8'h12, '0),
      row(1'b0, 8'h34, '0),
      row(1'b0, ubfr_pkg::END_BYTE, '{frame_done: 1'b1, frame_status: ubfr_pkg::FS_BAD_ADDR,
                                      default: '0}),
      row(1'b0, ubfr_pkg::START_BYTE, '0),   // ignored while holding
      row(1'b1, 8'h00, '0)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) byte_feed.push_back(directed_rows[i]);

    load_own_address(8'hFF);
    run_frames(50);

    load_own_address(8'($urandom_range(1, 254)));
    queue_frame(1'b1, 1'b0);
    queue_frame(1'b0, 1'b1);
    run_frames(50);

    load_own_address(8'h00);
    stall_request = 1'b1;
    run_frames(60);

    load_own_address(8'($urandom_range(1, 254)));
    quiet = 1'b1;
    run_frames(40);

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions, %0d payload bytes, own address 0x00, 0xFF and random,",
             transactions, payload_bytes);
    $display("one buffer wrap, one long sink stall; ok/addr/cmd/len/crc %0d/%0d/%0d/%0d/%0d",
             frame_reports[ubfr_pkg::FS_OK], frame_reports[ubfr_pkg::FS_BAD_ADDR],
             frame_reports[ubfr_pkg::FS_BAD_CMD], frame_reports[ubfr_pkg::FS_BAD_LEN],
             frame_reports[ubfr_pkg::FS_BAD_CRC]);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", failures);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ubfr_pkg.sv
rtl/core/ubfr_in_if.sv
rtl/core/ubfr_out_if.sv
rtl/core/ubfr_deframer.sv
rtl/core/uart_boot_frame_receiver.sv
tb/uart_boot_frame_receiver_tb.sv
